/* src/color_presence_bitmap_defines.svh */
// assertion macros for the color presence bitmap checker
`ifndef COLOR_PRESENCE_BITMAP_DEFINES_SVH
`define COLOR_PRESENCE_BITMAP_DEFINES_SVH

// property checked on every rising edge, quiet while reset is held
`define CPB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cpb check failed");

// property checked on every rising edge, reset included
`define CPB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("cpb check failed");

`endif

/* src/cpb_pkg.sv */
// shared types, codes and helpers of the color presence bitmap
`default_nettype none
package cpb_pkg;

    localparam int WORD_BITS      = 32;
    localparam int WORD_LOG       = 5;
    localparam int RED_BITS       = 6;
    localparam int OUT_COUNT_BITS = 25;
    localparam int IN_DATA_BITS   = 24;
    localparam int OUT_DATA_BITS  = 56;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_FETCH = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic cap;        // take the input beat
        logic clr_start;  // zero count and cursor, restart the sweep
        logic clr_step;   // write one zero word
        logic mark_rd;
        logic mark_wr;
        logic scan_start;
        logic scan_step;
        logic res_load;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic at_end;
        logic scan_done;
        logic out_busy;
    } t_status;

    // position of the lowest set bit, zero when none
    function automatic logic [WORD_LOG-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_LOG-1:0] pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) begin
                pos = WORD_LOG'(k);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

/* src/cpb_ctrl.sv */
// controller state machine of the color presence bitmap
`default_nettype none
module cpb_ctrl
    import cpb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_op,
    input  wire t_status    i_status,
    output logic            o_in_ready,
    output t_cmd            o_cmd
);

    t_state r_state, n_state;
    logic   r_emit, n_emit;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = r_emit ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_op)
                        OP_MARK:  n_state = ST_MARK_RD;
                        OP_FETCH: n_state = ST_SCAN_RD;
                        OP_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_emit  = 1'b1;
                        end
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: n_state = ST_DONE;
            ST_SCAN_RD: n_state = i_status.at_end ? ST_DONE : ST_SCAN;
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR:   o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.cap     = w_accept;
                o_cmd.clr_start = w_accept && (i_in_op == OP_CLEAR);
            end
            ST_MARK_RD: o_cmd.mark_rd = 1'b1;
            ST_MARK_WR: o_cmd.mark_wr = 1'b1;
            ST_SCAN_RD: o_cmd.scan_start = 1'b1;
            ST_SCAN:    o_cmd.scan_step = 1'b1;
            ST_DONE:    o_cmd.res_load = !i_status.out_busy;
            default:    o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* src/cpb_dpath.sv */
// datapath of the color presence bitmap: bit map memory, cursor, count, result register
`default_nettype none
module cpb_dpath
    import cpb_pkg::*;
#(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_wdata,
    input  wire logic [IN_DATA_BITS-1:0]   i_in_data,
    input  wire t_cmd                      i_cmd,
    input  wire logic                      i_out_ready,
    output t_status                        o_status,
    output logic                           o_out_valid,
    output logic                           o_out_found,
    output logic [OUT_DATA_BITS-1:0]       o_out_data
);

    localparam int IW = 3 * COMPONENT_BITS;
    localparam int AW = IW - WORD_LOG;
    localparam int CW = IW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int RED_IW = 3 * RED_BITS;
    localparam logic [CW-1:0] LIM_FULL = CW'(1) << IW;
    localparam logic [CW-1:0] LIM_RED  = CW'(1) << RED_IW;
    localparam logic [AW:0]   LIMW_FULL = (AW + 1)'(1) << AW;
    localparam logic [AW:0]   LIMW_RED  = (AW + 1)'(1) << (RED_IW - WORD_LOG);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    logic                 r_fd;
    logic [7:0]           r_red, r_green, r_blue;
    logic [AW-1:0]        r_clr_addr;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_cursor;
    logic [AW-1:0]        r_scan_word;
    logic                 r_first;
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [OUT_DATA_BITS-1:0] r_out_data;

    logic [IW-1:0]        w_mark_idx;
    logic                 w_mark_new;
    logic [CW-1:0]        w_limit;
    logic [AW:0]          w_limit_words;
    logic [AW:0]          w_next_word;
    logic                 w_last_word;
    logic [WORD_BITS-1:0] w_masked;
    logic                 w_hit;
    logic [IW-1:0]        w_hit_idx;
    logic [AW-1:0]        w_addr;
    logic                 w_we;
    logic [WORD_BITS-1:0] w_wdata;
    logic [7:0]           w_res_red, w_res_green, w_res_blue;

    // color index, red-major
    always_comb begin
        if (r_fd) begin
            w_mark_idx = {r_red[7 -: COMPONENT_BITS], r_green[7 -: COMPONENT_BITS],
                          r_blue[7 -: COMPONENT_BITS]};
        end else begin
            w_mark_idx = IW'({r_red[7:2], r_green[7:2], r_blue[7:2]});
        end
    end

    assign w_mark_new    = !r_rdata[w_mark_idx[WORD_LOG-1:0]];
    assign w_limit       = r_fd ? LIM_FULL : LIM_RED;
    assign w_limit_words = r_fd ? LIMW_FULL : LIMW_RED;
    assign w_next_word   = {1'b0, r_scan_word} + (AW + 1)'(1);
    assign w_last_word   = (w_next_word == w_limit_words);

    // bits below the cursor are masked off, in the first word only
    assign w_masked  = r_first ? (r_rdata & ({WORD_BITS{1'b1}} << r_cursor[WORD_LOG-1:0]))
                               : r_rdata;
    assign w_hit     = |w_masked;
    assign w_hit_idx = {r_scan_word, lowest_set(w_masked)};

    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        w_addr  = w_next_word[AW-1:0];
        if (i_cmd.clr_step) begin
            w_addr = r_clr_addr;
            w_we   = 1'b1;
        end else if (i_cmd.mark_rd || i_cmd.mark_wr) begin
            w_addr  = w_mark_idx[IW-1:WORD_LOG];
            w_we    = i_cmd.mark_wr && w_mark_new;
            w_wdata = r_rdata | (WORD_BITS'(1) << w_mark_idx[WORD_LOG-1:0]);
        end else if (i_cmd.scan_start) begin
            w_addr = r_cursor[IW-1:WORD_LOG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rdata <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_red   <= i_in_data[7:0];
            r_green <= i_in_data[15:8];
            r_blue  <= i_in_data[23:16];
        end
        if (i_cmd.scan_start) begin
            r_scan_word <= r_cursor[IW-1:WORD_LOG];
            r_first     <= 1'b1;
        end else if (i_cmd.scan_step) begin
            r_scan_word <= w_next_word[AW-1:0];
            r_first     <= 1'b0;
        end
        if (i_cmd.scan_step && w_hit) begin
            r_hit_idx <= w_hit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd       <= 1'b0;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_cursor   <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fd <= i_cfg_wdata;
            end
            if (i_cmd.cap) begin
                r_hit <= 1'b0;
            end
            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
                r_count    <= '0;
                r_cursor   <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.mark_wr && w_mark_new) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_step) begin
                if (w_hit) begin
                    r_hit    <= 1'b1;
                    r_cursor <= {1'b0, w_hit_idx} + CW'(1);
                end else if (w_last_word) begin
                    r_cursor <= w_limit;
                end
            end
        end
    end

    // scale the found color back to the 0-255 range
    always_comb begin
        if (r_fd) begin
            w_res_red   = 8'(r_hit_idx[IW-1 -: COMPONENT_BITS]) << (8 - COMPONENT_BITS);
            w_res_green = 8'(r_hit_idx[2*COMPONENT_BITS-1 -: COMPONENT_BITS])
                          << (8 - COMPONENT_BITS);
            w_res_blue  = 8'(r_hit_idx[COMPONENT_BITS-1:0]) << (8 - COMPONENT_BITS);
        end else begin
            w_res_red   = {r_hit_idx[17:12], 2'b00};
            w_res_green = {r_hit_idx[11:6], 2'b00};
            w_res_blue  = {r_hit_idx[5:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_found <= r_hit;
            r_out_data  <= {7'd0, OUT_COUNT_BITS'(r_count),
                            r_hit ? {w_res_blue, w_res_green, w_res_red} : 24'd0};
        end
    end

    assign o_status.clr_last  = (r_clr_addr == {AW{1'b1}});
    assign o_status.at_end    = (r_cursor >= w_limit);
    assign o_status.scan_done = w_hit || w_last_word;
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

/* src/color_presence_bitmap.sv */
// Color presence bitmap: one bit per RGB color, with mark, fetch-next and clear.
// Input beats arrive on s_axis: tuser carries the operation (mark, fetch, clear),
// tdata carries red, green and blue. Every accepted beat gives one result beat on
// m_axis: tuser is the found flag, tdata the fetched color and the distinct count.
// i_cfg_we / i_cfg_wdata select COMPONENT_BITS-bit (1) or 6-bit (0) components; write it idle.
// The map sits in a single-port memory of 32-bit words, one access per cycle.
// Mark: read-modify-write of one word (MARK_RD, MARK_WR), result loaded in DONE.
// Fetch: reads the word at the cursor, then scans one 32-bit word per cycle from the
// cursor, so up to 2^(3*COMPONENT_BITS-5) words when the map is sparse.
// Clear: sweeps all 2^(3*COMPONENT_BITS-5) words, one per cycle, then reports.
// After reset the same sweep runs with s_axis_tready low; configuration writes
// are taken during it.
// One item is in work at a time; a new beat is taken once the previous result sits
// in the output register. If m_axis_tready stays low the result holds there and the
// following item waits before reporting.
`default_nettype none
module color_presence_bitmap
    import cpb_pkg::*;
#(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_wdata,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // red, green, blue
    input  wire logic [1:0]               s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,  // out_red, out_green, out_blue,
                                                         // distinct_count, zero pad
    output logic                          m_axis_tuser   // found
);

    t_cmd    w_cmd;
    t_status w_status;

    cpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    cpb_dpath #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_found (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

/* src/cpb_checker.sv */
// port-level checks of the color presence bitmap and their bind
`default_nettype none
`include "color_presence_bitmap_defines.svh"
module cpb_checker
    import cpb_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input wire logic                     m_axis_tuser
);

    // a stalled result beat holds
    `CPB_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // no color without the found flag
    `CPB_ASSERT(a_notfound_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:0] == 24'd0)

    // a found color means the map holds at least one color
    `CPB_ASSERT(a_found_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[48:24] != 25'd0)

    // nothing is reported right after reset
    `CPB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind color_presence_bitmap cpb_checker u_cpb_checker (.*);
`default_nettype wire
